FILE: rtl/sfrp_pkg.sv
// ----------------------------------------------------------------------------
// sfrp_pkg
// Shared types, codes and decode helpers for the servo status reply parser.
// ----------------------------------------------------------------------------
package sfrp_pkg;

  localparam int DATA_BYTES_DEF = 15;
  localparam int COUNT_W        = 6;
  localparam int FIELD_BYTES    = 15;
  localparam int IDX_W          = $clog2(FIELD_BYTES);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] POS_ID    = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_LEN   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] POS_ERR   = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] POS_DATA  = COUNT_W'(5);

  localparam logic [7:0] SUM_GOOD = 8'hFF;

  localparam logic CFG_EXPECTED_ID = 1'b0;
  localparam logic CFG_HEADER_BYTE = 1'b1;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_SIZE     = 3'd1,
    VERDICT_HEADER   = 3'd2,
    VERDICT_ID       = 3'd3,
    VERDICT_LENGTH   = 3'd4,
    VERDICT_CHECKSUM = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [7:0]         sum;
    logic               header_ok;
    logic               id_ok;
    logic               length_ok;
    logic [7:0]         saved_id;
    logic [7:0]         saved_error;
  } frame_status_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [7:0]         reply_id;
    logic [7:0]         error_byte;
    logic signed [15:0] position;
    logic signed [15:0] speed;
    logic signed [10:0] load;
    logic [7:0]         voltage;
    logic [7:0]         temperature;
    logic [7:0]         servo_state;
    logic               moving;
    logic signed [15:0] current;
  } result_t;

  function automatic logic [15:0] sm15(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? (16'd0 - mag) : mag;
  endfunction

  function automatic logic [10:0] sm10(input logic [15:0] raw);
    logic [10:0] mag;
    mag = {1'b0, raw[9:0]};
    return raw[10] ? (11'd0 - mag) : mag;
  endfunction

endpackage

FILE: rtl/sfrp_decode.sv
// ----------------------------------------------------------------------------
// sfrp_decode
// Verdict priority and field decode for one completed reply frame.
// ----------------------------------------------------------------------------
module sfrp_decode #(
  parameter int DATA_BYTES = sfrp_pkg::DATA_BYTES_DEF
) (
  input  sfrp_pkg::frame_status_t                             status,
  input  logic [sfrp_pkg::FIELD_BYTES-1:0][7:0]               payload,
  output sfrp_pkg::result_t                                   result
);
  import sfrp_pkg::*;

  localparam logic [COUNT_W-1:0] FRAME_LEN = COUNT_W'(DATA_BYTES + 6);

  verdict_t verdict;

  always_comb begin
    if (status.count != FRAME_LEN) begin
      verdict = VERDICT_SIZE;
    end else if (!status.header_ok) begin
      verdict = VERDICT_HEADER;
    end else if (!status.id_ok) begin
      verdict = VERDICT_ID;
    end else if (!status.length_ok) begin
      verdict = VERDICT_LENGTH;
    end else if (status.sum != SUM_GOOD) begin
      verdict = VERDICT_CHECKSUM;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    result = '0;
    result.verdict = verdict;
    if (verdict == VERDICT_OK) begin
      result.reply_id    = status.saved_id;
      result.error_byte  = status.saved_error;
      result.position    = sm15({payload[1], payload[0]});
      result.speed       = sm15({payload[3], payload[2]});
      result.load        = sm10({payload[5], payload[4]});
      result.voltage     = payload[6];
      result.temperature = payload[7];
      result.servo_state = payload[9];
      result.moving      = (payload[10] != 8'd0);
      result.current     = sm15({payload[14], payload[13]});
    end
  end

endmodule

FILE: rtl/servo_feedback_reply_parser_unit.sv
// ----------------------------------------------------------------------------
// servo_feedback_reply_parser_unit
// Byte-wise parser for servo status replies; one verdict item per frame.
// A frame's result goes to the result register as its last byte is accepted,
// or to the one-entry skid behind it while that register holds an item.
// Bytes are taken one per cycle while the skid is empty, set by the single
// frame-state update between the input handshake and the result register;
// a full skid stops the input. Reset clears the frame state, the result and
// skid valid bits, and sets the servo id to 1 and header_byte to 255.
// ----------------------------------------------------------------------------
module servo_feedback_reply_parser_unit #(
  parameter int DATA_BYTES = sfrp_pkg::DATA_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic         s_tlast,   // frame_end
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] reply_id, [15:8] error_byte, [31:16] position, [47:32] speed,
  // [58:48] load, [66:59] voltage, [74:67] temperature, [82:75] servo_state,
  // [83] moving, [99:84] current, [103:100] zero
  output logic [103:0] m_tdata,
  output logic [2:0]   m_tuser,   // [2:0] verdict
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);
  import sfrp_pkg::*;

  localparam logic [7:0] LEN_BYTE = 8'(DATA_BYTES + 2);

  localparam frame_status_t FRAME_IDLE = '{
    count:       '0,
    sum:         '0,
    header_ok:   1'b1,
    id_ok:       1'b1,
    length_ok:   1'b1,
    saved_id:    '0,
    saved_error: '0
  };

  logic [7:0] servo_id;
  logic [7:0] header_byte;

  frame_status_t                   status;
  frame_status_t                   status_next;
  logic [FIELD_BYTES-1:0][7:0]     payload;
  logic [FIELD_BYTES-1:0][7:0]     payload_next;
  logic [COUNT_W-1:0]              wr_off;
  logic [IDX_W-1:0]                wr_idx;

  result_t result;
  result_t out_reg;
  result_t skid;
  logic    out_valid;
  logic    skid_valid;
  logic    accept;
  logic    produce;
  logic    take;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign produce  = accept && s_tlast;
  assign take     = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id    <= 8'd1;
      header_byte <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_ID: servo_id <= cfg_data;
        CFG_HEADER_BYTE: header_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wr_off = status.count - POS_DATA;
  assign wr_idx = wr_off[IDX_W-1:0];

  always_comb begin
    status_next  = status;
    payload_next = payload;
    if (status.count < POS_ID) begin
      if (s_tdata != header_byte) begin
        status_next.header_ok = 1'b0;
      end
    end else begin
      status_next.sum = status.sum + s_tdata;
      if (status.count == POS_ID) begin
        status_next.saved_id = s_tdata;
        status_next.id_ok    = (s_tdata == servo_id);
      end else if (status.count == POS_LEN) begin
        status_next.length_ok = (s_tdata == LEN_BYTE);
      end else if (status.count == POS_ERR) begin
        status_next.saved_error = s_tdata;
      end else if (wr_off < COUNT_W'(FIELD_BYTES)) begin
        payload_next[wr_idx] = s_tdata;
      end
    end
    if (status.count != COUNT_MAX) begin
      status_next.count = status.count + 1'b1;
    end
  end

  sfrp_decode #(
    .DATA_BYTES (DATA_BYTES)
  ) u_decode (
    .status  (status_next),
    .payload (payload_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= FRAME_IDLE;
    end else if (accept) begin
      if (s_tlast) begin
        status <= FRAME_IDLE;
      end else begin
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      payload <= payload_next;
    end
  end

  // result register with a one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (produce) begin
        out_reg <= result;
      end
    end else if (produce) begin
      skid <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_reg.verdict;
  assign m_tdata  = {4'd0, out_reg.current, out_reg.moving, out_reg.servo_state,
                     out_reg.temperature, out_reg.voltage, out_reg.load,
                     out_reg.speed, out_reg.position, out_reg.error_byte,
                     out_reg.reply_id};

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    produce |=> status.count == '0)
    else $error("frame state not cleared after last byte");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while result register is empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    produce && out_valid && !m_tready |=> skid_valid)
    else $error("result lost while output stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.verdict != VERDICT_OK |-> m_tdata == '0)
    else $error("decoded fields not zero on error verdict");

endmodule

FILE: tb/reply_frame_checker.sv
// ----------------------------------------------------------------------------
// reply_frame_checker
// Watches the byte, result and register ports of the servo reply parser,
// tracks the frame state of every reply on its own and checks each
// verdict item, field by field, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module reply_frame_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  output int           pending,
  output int           fail_count
);
  import sfrp_pkg::*;

  localparam int NDATA = DATA_BYTES_DEF;
  localparam int FRAME_LEN = NDATA + 6;
  localparam logic [7:0] LEN_FIELD = 8'(NDATA + 2);
  localparam int FIRST_DATA = 5;

  logic [7:0] want_id;
  logic [7:0] want_hdr;
  logic [5:0] nbytes;
  logic [7:0] csum;
  logic       hdr_good;
  logic       id_good;
  logic       len_good;
  logic [7:0] kept_id;
  logic [7:0] kept_err;
  logic [7:0] data_mem [NDATA];
  result_t    verdicts_due [$];
  result_t    want;
  result_t    got;
  int         errors = 0;

  initial begin
    pending = 0;
    fail_count = 0;
  end

  function automatic logic signed [15:0] mag_sign16(input logic [15:0] w);
    logic signed [15:0] m;
    m = {1'b0, w[14:0]};
    return w[15] ? -m : m;
  endfunction

  function automatic logic signed [10:0] mag_sign11(input logic [15:0] w);
    logic signed [10:0] m;
    m = {1'b0, w[9:0]};
    return w[10] ? -m : m;
  endfunction

  task automatic clear_frame;
    nbytes = '0;
    csum = '0;
    hdr_good = 1'b1;
    id_good = 1'b1;
    len_good = 1'b1;
    kept_id = '0;
    kept_err = '0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (nbytes < 2) begin
      if (b != want_hdr) hdr_good = 1'b0;
    end else begin
      csum = csum + b;
      if (nbytes == 2) begin
        kept_id = b;
        id_good = (b == want_id);
      end else if (nbytes == 3) begin
        len_good = (b == LEN_FIELD);
      end else if (nbytes == 4) begin
        kept_err = b;
      end else if (nbytes < FIRST_DATA + NDATA) begin
        data_mem[nbytes - FIRST_DATA] = b;
      end
    end
    if (nbytes != '1) nbytes = nbytes + 1'b1;
    if (last) begin
      r = '0;
      if (nbytes != FRAME_LEN) r.verdict = VERDICT_SIZE;
      else if (!hdr_good) r.verdict = VERDICT_HEADER;
      else if (!id_good) r.verdict = VERDICT_ID;
      else if (!len_good) r.verdict = VERDICT_LENGTH;
      else if (csum != 8'hFF) r.verdict = VERDICT_CHECKSUM;
      else r.verdict = VERDICT_OK;
      if (r.verdict == VERDICT_OK) begin
        r.reply_id = kept_id;
        r.error_byte = kept_err;
        r.position = mag_sign16({data_mem[1], data_mem[0]});
        r.speed = mag_sign16({data_mem[3], data_mem[2]});
        r.load = mag_sign11({data_mem[5], data_mem[4]});
        r.voltage = data_mem[6];
        r.temperature = data_mem[7];
        r.servo_state = data_mem[9];
        r.moving = (data_mem[10] != 8'h00);
        r.current = mag_sign16({data_mem[14], data_mem[13]});
      end
      verdicts_due.insert(verdicts_due.size(), r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_id = 8'd1;
      want_hdr = 8'hFF;
      clear_frame();
      verdicts_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.verdict = verdict_t'(m_tuser);
        got.reply_id = m_tdata[7:0];
        got.error_byte = m_tdata[15:8];
        got.position = m_tdata[31:16];
        got.speed = m_tdata[47:32];
        got.load = m_tdata[58:48];
        got.voltage = m_tdata[66:59];
        got.temperature = m_tdata[74:67];
        got.servo_state = m_tdata[82:75];
        got.moving = m_tdata[83];
        got.current = m_tdata[99:84];
        if (verdicts_due.size() == 0) begin
          $error("verdict item with none outstanding: verdict %0d", m_tuser);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("verdict", int'(want.verdict), int'(got.verdict));
          check_field("reply_id", int'(want.reply_id), int'(got.reply_id));
          check_field("error_byte", int'(want.error_byte), int'(got.error_byte));
          check_field("position", int'(want.position), int'(got.position));
          check_field("speed", int'(want.speed), int'(got.speed));
          check_field("load", int'(want.load), int'(got.load));
          check_field("voltage", int'(want.voltage), int'(got.voltage));
          check_field("temperature", int'(want.temperature), int'(got.temperature));
          check_field("servo_state", int'(want.servo_state), int'(got.servo_state));
          check_field("moving", int'(want.moving), int'(got.moving));
          check_field("current", int'(want.current), int'(got.current));
          check_field("pad", 0, int'(m_tdata[103:100]));
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
      if (cfg_we) begin
        if (cfg_index == CFG_EXPECTED_ID) want_id = cfg_data;
        else want_hdr = cfg_data;
      end
    end
    pending <= verdicts_due.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds the servo reply parser with directed and random reply frames,
// good and broken, under random idling on both sides and changing
// register settings; the checker beside the block judges every verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import sfrp_pkg::*;

  localparam int NDATA = DATA_BYTES_DEF;
  localparam int FRAME_LEN = NDATA + 6;
  localparam logic [7:0] LEN_FIELD = 8'(NDATA + 2);
  localparam int RANDOM_BYTES = 625;
  localparam int CFG_SPACING = 200;
  localparam int LONG_FRAME = 70;
  localparam int QUIET_CYCLES = 4;
  localparam int HOLD_CYCLES = 1500;
  localparam int CYCLE_LIMIT = 300000;

  localparam int F_ID = 2;
  localparam int F_LEN = 3;
  localparam int F_ERR = 4;
  localparam int F_CHK = FRAME_LEN - 1;

  localparam int D_POSITION = 0;
  localparam int D_SPEED = 2;
  localparam int D_LOAD = 4;
  localparam int D_MOVING = 10;
  localparam int D_CURRENT = 13;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [7:0]   cfg_data = '0;
  int           pending;
  int           fail_count;
  int           cycle_count = 0;
  int           sent_bytes = 0;
  int           taken = 0;
  logic [7:0]   cur_id = 8'd1;
  logic [7:0]   cur_hdr = 8'hFF;
  logic         tx_calm = 1'b0;
  logic         rx_calm = 1'b0;
  logic [7:0]   frame_buf [$];
  logic [7:0]   data_buf [NDATA];

  servo_feedback_reply_parser_unit i_dut (.*);

  reply_frame_checker i_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : result_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 16 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (taken == 25 || taken == 40) gap = HOLD_CYCLES;
      else if (rx_calm) gap = 0;
      else gap = $urandom_range(0, 13);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame(input int from);
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int k = from; k < frame_buf.size(); k++)
      send_byte(frame_buf[k], k == frame_buf.size() - 1);
  endtask

  // drop the byte stream and wait until every verdict is out
  task automatic settle;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_EXPECTED_ID) cur_id = v;
    else cur_hdr = v;
  endtask

  function automatic logic [7:0] pick_reg_value;
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic fill_data(input int mode);
    for (int k = 0; k < NDATA; k++) begin
      case (mode)
        FILL_ZERO: data_buf[k] = 8'h00;
        FILL_ONES: data_buf[k] = 8'hFF;
        default: data_buf[k] = 8'($urandom);
      endcase
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  task automatic compose_reply(input logic [7:0] hdr, input logic [7:0] id,
                               input logic [7:0] err);
    logic [7:0] acc;
    acc = id + LEN_FIELD + err;
    frame_buf.delete();
    add_byte(hdr);
    add_byte(hdr);
    add_byte(id);
    add_byte(LEN_FIELD);
    add_byte(err);
    for (int k = 0; k < NDATA; k++) begin
      add_byte(data_buf[k]);
      acc = acc + data_buf[k];
    end
    add_byte(~acc);
  endtask

  task automatic cut_to(input int n);
    while (frame_buf.size() > n) void'(frame_buf.pop_back());
  endtask

  task automatic pad_to(input int n);
    while (frame_buf.size() < n) add_byte(8'($urandom));
  endtask

  initial begin : stimulus
    int start;
    int next_cfg_at;
    int kind;
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    fill_data(FILL_RANDOM);
    compose_reply(cur_hdr, cur_id, 8'($urandom));
    send_frame(0);
    fill_data(FILL_ZERO);
    compose_reply(cur_hdr, cur_id, 8'h00);
    send_frame(0);
    fill_data(FILL_ONES);
    compose_reply(cur_hdr, cur_id, 8'hFF);
    send_frame(0);
    // negative zero in every sign-magnitude field
    fill_data(FILL_ZERO);
    data_buf[D_POSITION + 1] = 8'h80;
    data_buf[D_SPEED + 1] = 8'h80;
    data_buf[D_LOAD + 1] = 8'h04;
    data_buf[D_CURRENT + 1] = 8'h80;
    data_buf[D_MOVING] = 8'h01;
    compose_reply(cur_hdr, cur_id, 8'h5A);
    send_frame(0);
    // load bits above the sign are ignored
    fill_data(FILL_RANDOM);
    data_buf[D_LOAD] = 8'hFF;
    data_buf[D_LOAD + 1] = 8'hFB;
    compose_reply(cur_hdr, cur_id, 8'h00);
    send_frame(0);

    fill_data(FILL_RANDOM);
    compose_reply(cur_hdr, cur_id, 8'h00);
    cut_to(1);
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h00);
    cut_to(FRAME_LEN - 1);
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h00);
    pad_to(FRAME_LEN + 1);
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h00);
    pad_to(LONG_FRAME);
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h00);
    frame_buf[0] = frame_buf[0] ^ 8'h01;
    cut_to(FRAME_LEN - 3);
    send_frame(0);

    compose_reply(cur_hdr, cur_id, 8'h11);
    frame_buf[0] = frame_buf[0] ^ 8'h01;
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h11);
    frame_buf[1] = frame_buf[1] ^ 8'h80;
    frame_buf[F_CHK] = frame_buf[F_CHK] ^ 8'h01;
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h22);
    frame_buf[F_ID] = frame_buf[F_ID] ^ 8'h01;
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h33);
    frame_buf[F_LEN] = frame_buf[F_LEN] ^ 8'h01;
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'h44);
    frame_buf[F_CHK] = frame_buf[F_CHK] ^ 8'h01;
    send_frame(0);

    // change both registers between the header and the id of one reply
    fill_data(FILL_RANDOM);
    compose_reply(cur_hdr, 8'h42, 8'h00);
    send_byte(frame_buf[0], 1'b0);
    send_byte(frame_buf[1], 1'b0);
    write_reg(CFG_EXPECTED_ID, 8'h42);
    write_reg(CFG_HEADER_BYTE, 8'h5A);
    send_frame(F_ID);

    write_reg(CFG_EXPECTED_ID, 8'h00);
    write_reg(CFG_HEADER_BYTE, 8'h00);
    fill_data(FILL_RANDOM);
    compose_reply(cur_hdr, cur_id, 8'($urandom));
    send_frame(0);
    write_reg(CFG_EXPECTED_ID, 8'hFF);
    write_reg(CFG_HEADER_BYTE, 8'hFF);
    compose_reply(cur_hdr, cur_id, 8'($urandom));
    send_frame(0);
    compose_reply(cur_hdr, cur_id, 8'($urandom));
    frame_buf[F_ERR] = frame_buf[F_ERR] ^ 8'($urandom_range(1, 255));
    send_frame(0);

    start = sent_bytes;
    next_cfg_at = sent_bytes + CFG_SPACING;
    while (sent_bytes - start < RANDOM_BYTES) begin
      if (sent_bytes >= next_cfg_at) begin
        write_reg(CFG_EXPECTED_ID, pick_reg_value());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_HEADER_BYTE, pick_reg_value());
        next_cfg_at = sent_bytes + CFG_SPACING;
      end
      case ($urandom_range(0, 9))
        0: fill_data(FILL_ZERO);
        1: fill_data(FILL_ONES);
        default: fill_data(FILL_RANDOM);
      endcase
      compose_reply(cur_hdr, cur_id, 8'($urandom));
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
      end else if (kind < 67) begin
        n = $urandom_range(0, 1);
        frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      end else if (kind < 72) begin
        frame_buf[F_ID] = frame_buf[F_ID] ^ 8'($urandom_range(1, 255));
      end else if (kind < 77) begin
        frame_buf[F_LEN] = frame_buf[F_LEN] ^ 8'($urandom_range(1, 255));
      end else if (kind < 85) begin
        n = $urandom_range(F_ERR, F_CHK);
        frame_buf[n] = frame_buf[n] ^ 8'($urandom_range(1, 255));
      end else if (kind < 90) begin
        cut_to($urandom_range(1, FRAME_LEN - 1));
      end else if (kind < 95) begin
        pad_to($urandom_range(FRAME_LEN + 1, LONG_FRAME));
      end else begin
        frame_buf.delete();
        pad_to($urandom_range(1, 30));
      end
      send_frame(0);
    end

    settle();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
